// File: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the biquad checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define BQ_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`endif

// File: sv/bqtdf2_pkg.sv
// ---------------------------------------------------------------------------
// bqtdf2_pkg
// Types, constants and command encodings shared by the biquad modules.
// ---------------------------------------------------------------------------
package bqtdf2_pkg;

   localparam int FRACTION_BITS = 12;
   localparam int Q15_BITS      = 15;
   localparam int UP_SHIFT      = Q15_BITS - FRACTION_BITS;

   localparam int SAMPLE_W = 16;
   localparam int COEF_W   = 16;
   localparam int STATE_W  = 32;
   localparam int PROD_W   = STATE_W + COEF_W;
   localparam int INDEX_W  = 3;

   localparam logic signed [COEF_W-1:0] COEF_B0_RESET = 16'sd589;
   localparam logic signed [COEF_W-1:0] COEF_B1_RESET = 16'sd0;
   localparam logic signed [COEF_W-1:0] COEF_B2_RESET = 16'sd589;
   localparam logic signed [COEF_W-1:0] COEF_A1_RESET = -16'sd6812;
   localparam logic signed [COEF_W-1:0] COEF_A2_RESET = 16'sd3317;

   // Coefficient selection; the codes double as register indexes.
   typedef enum logic [INDEX_W-1:0] {
      COEF_B0 = 3'd0,
      COEF_B1 = 3'd1,
      COEF_B2 = 3'd2,
      COEF_A1 = 3'd3,
      COEF_A2 = 3'd4
   } coef_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_P_PLUS_D2,
      ACC_MINUS_P,
      ACC_LOAD_P
   } acc_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_B0,
      ST_Y,
      ST_A1,
      ST_B2,
      ST_A2,
      ST_D2
   } state_type;

   typedef struct packed {
      logic         load_x;
      logic         mul_en;
      logic         mul_y;
      coef_sel_type coef;
      logic         load_y;
      acc_op_type   acc_op;
      logic         load_d1;
      logic         load_d2;
      logic         load_out;
   } dp_cmd_type;

endpackage

// File: sv/bqtdf2_datapath.sv
// ---------------------------------------------------------------------------
// bqtdf2_datapath
// Coefficient registers, shared multiplier, accumulator and delay words.
// ---------------------------------------------------------------------------
module bqtdf2_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bqtdf2_pkg::dp_cmd_type               cmd,
   input  logic signed [bqtdf2_pkg::SAMPLE_W-1:0] sample_in,
   input  logic                                 csr_wen,
   input  logic [bqtdf2_pkg::INDEX_W-1:0]       csr_index,
   input  logic [bqtdf2_pkg::COEF_W-1:0]        csr_wdata,
   output logic signed [bqtdf2_pkg::SAMPLE_W-1:0] sample_out
);
   import bqtdf2_pkg::*;

   logic signed [COEF_W-1:0]   b0_ff, b1_ff, b2_ff, a1_ff, a2_ff;
   logic signed [SAMPLE_W-1:0] x_ff;
   logic signed [STATE_W-1:0]  y_ff, p_ff, acc_ff, d1_ff, d2_ff;
   logic signed [SAMPLE_W-1:0] out_ff;

   logic signed [STATE_W-1:0]  opa;
   logic signed [COEF_W-1:0]   coef;
   logic signed [PROD_W-1:0]   prod_full;
   logic signed [STATE_W-1:0]  p_in;
   logic signed [STATE_W-1:0]  acc_in;

   // Coefficient file; indexes beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         b0_ff <= COEF_B0_RESET;
         b1_ff <= COEF_B1_RESET;
         b2_ff <= COEF_B2_RESET;
         a1_ff <= COEF_A1_RESET;
         a2_ff <= COEF_A2_RESET;
      end else if (csr_wen) begin
         if (csr_index == COEF_B0) b0_ff <= $signed(csr_wdata);
         if (csr_index == COEF_B1) b1_ff <= $signed(csr_wdata);
         if (csr_index == COEF_B2) b2_ff <= $signed(csr_wdata);
         if (csr_index == COEF_A1) a1_ff <= $signed(csr_wdata);
         if (csr_index == COEF_A2) a2_ff <= $signed(csr_wdata);
      end
   end

   always_comb begin
      unique case (cmd.coef)
         COEF_B0: coef = b0_ff;
         COEF_B1: coef = b1_ff;
         COEF_B2: coef = b2_ff;
         COEF_A1: coef = a1_ff;
         COEF_A2: coef = a2_ff;
         default: coef = b0_ff;
      endcase
   end

   assign opa       = cmd.mul_y ? y_ff : STATE_W'(x_ff);
   assign prod_full = opa * coef;
   // The low word matches a 32-bit multiply of sign-extended operands.
   assign p_in      = $signed(prod_full[STATE_W-1:0]) >>> FRACTION_BITS;

   always_comb begin
      unique case (cmd.acc_op)
         ACC_HOLD:      acc_in = acc_ff;
         ACC_P_PLUS_D2: acc_in = p_ff + d2_ff;
         ACC_MINUS_P:   acc_in = acc_ff - p_ff;
         ACC_LOAD_P:    acc_in = p_ff;
         default:       acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_ff <= '0;
         d2_ff <= '0;
      end else begin
         if (cmd.load_d1) d1_ff <= acc_ff;
         if (cmd.load_d2) d2_ff <= acc_ff - p_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_x)   x_ff   <= sample_in >>> UP_SHIFT;
      if (cmd.mul_en)   p_ff   <= p_in;
      if (cmd.load_y)   y_ff   <= p_ff + d1_ff;
      acc_ff <= acc_in;
      if (cmd.load_out) out_ff <= SAMPLE_W'(y_ff <<< UP_SHIFT);
   end

   assign sample_out = out_ff;

endmodule

// File: sv/bqtdf2_control.sv
// ---------------------------------------------------------------------------
// bqtdf2_control
// Sequencer for the shared multiplier and the result handshake.
// ---------------------------------------------------------------------------
module bqtdf2_control (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output bqtdf2_pkg::dp_cmd_type cmd
);
   import bqtdf2_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // The result register may be refilled once its item is gone or leaves now.
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_B0;
         ST_B0:   state_in = ST_Y;
         ST_Y:    state_in = ST_A1;
         ST_A1:   state_in = ST_B2;
         ST_B2:   state_in = ST_A2;
         ST_A2:   state_in = ST_D2;
         ST_D2:   if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '{load_x: 1'b0, mul_en: 1'b0, mul_y: 1'b0, coef: COEF_B0,
                       load_y: 1'b0, acc_op: ACC_HOLD, load_d1: 1'b0,
                       load_d2: 1'b0, load_out: 1'b0};
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.load_x = req_valid;
         end
         ST_B0: begin
            cmd.mul_en = 1'b1;
            cmd.coef   = COEF_B0;
         end
         ST_Y: begin
            cmd.load_y = 1'b1;
            cmd.mul_en = 1'b1;
            cmd.coef   = COEF_B1;
         end
         ST_A1: begin
            cmd.acc_op = ACC_P_PLUS_D2;
            cmd.mul_en = 1'b1;
            cmd.mul_y  = 1'b1;
            cmd.coef   = COEF_A1;
         end
         ST_B2: begin
            cmd.acc_op = ACC_MINUS_P;
            cmd.mul_en = 1'b1;
            cmd.coef   = COEF_B2;
         end
         ST_A2: begin
            cmd.load_d1 = 1'b1;
            cmd.acc_op  = ACC_LOAD_P;
            cmd.mul_en  = 1'b1;
            cmd.mul_y   = 1'b1;
            cmd.coef    = COEF_A2;
         end
         ST_D2: begin
            cmd.load_d2  = out_free;
            cmd.load_out = out_free;
            if (out_free) rsp_valid_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: sv/biquad_fixed_point_tdf2.sv
// ---------------------------------------------------------------------------
// biquad_fixed_point_tdf2
// Second-order IIR section, transposed direct form II, Q15 in and out.
// ---------------------------------------------------------------------------
// rsp_valid rises once the item has passed states B0, Y, A1, B2, A2 and D2;
// D2 waits while the result register is full. Throughput is set by the
// single shared 32 x 16 multiplier forming five coefficient products in turn.
// A finished result waits in its own register while the next item is taken.
// Reset (synchronous, active high) zeroes both delay words, restores the
// default coefficients and empties the result register.
module biquad_fixed_point_tdf2 (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [bqtdf2_pkg::SAMPLE_W-1:0] req_sample_in,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [bqtdf2_pkg::SAMPLE_W-1:0] rsp_sample_out,
   input  logic                                   csr_wen,
   input  logic [bqtdf2_pkg::INDEX_W-1:0]         csr_index,
   input  logic [bqtdf2_pkg::COEF_W-1:0]          csr_wdata
);
   import bqtdf2_pkg::*;

   // Command word from the sequencer to the datapath, one field per action.
   dp_cmd_type cmd;

   // The sequencer steps through the products in the order
   // x*b0, x*b1, y*a1, x*b2, y*a2, folding each into y, the accumulator
   // or a delay word in the state after the one that registers it.
   bqtdf2_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // The datapath holds the coefficients, the delay words and the result
   // register. All sums wrap in two's complement and the output keeps only
   // the low sixteen bits of the rescaled y.
   bqtdf2_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sample_in  (req_sample_in),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .sample_out (rsp_sample_out)
   );

endmodule

// File: sv/bqtdf2_checker.sv
// ---------------------------------------------------------------------------
// bqtdf2_checker
// Port-level checks on the biquad's handshake and sequencing.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bqtdf2_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_ready,
   input logic signed [bqtdf2_pkg::SAMPLE_W-1:0] req_sample_in,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic signed [bqtdf2_pkg::SAMPLE_W-1:0] rsp_sample_out,
   input logic                                   csr_wen,
   input logic [bqtdf2_pkg::INDEX_W-1:0]         csr_index,
   input logic [bqtdf2_pkg::COEF_W-1:0]          csr_wdata
);
   logic unused_inputs;
   assign unused_inputs = ^{req_sample_in, csr_wen, csr_index, csr_wdata};

   `BQ_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "result item dropped")
   `BQ_ASSERT(a_rsp_stable, rsp_valid && !rsp_ready |=> $stable(rsp_sample_out), "result changed")
   `BQ_ASSERT(a_busy_after_accept, req_valid && req_ready |=> !req_ready, "accepted while busy")
   `BQ_ASSERT(a_rsp_from_work, $rose(rsp_valid) |-> !$past(req_ready), "result without work")

endmodule

bind biquad_fixed_point_tdf2 bqtdf2_checker u_checker (.*);
